>>> rtl/core/pks_pkg.sv
// Package for the PDF keyword threat scanner: types, keyword constants,
// weights and helper functions. Used by every file under rtl/core.
package pks_pkg;

  localparam int unsigned KW_COUNT  = 6;
  localparam int unsigned HIST_LEN  = 12;
  localparam logic [3:0]  MIN_LEN   = 4'd8;
  localparam logic [3:0]  HDR_LEN   = 4'd4;
  localparam logic [7:0]  THRESH_RESET = 8'd80;

  // configuration register indexes
  localparam logic [0:0] CFG_PDF_BY_NAME = 1'b0;
  localparam logic [0:0] CFG_THRESHOLD   = 1'b1;

  // keyword text, last character in the low byte
  localparam logic [87:0]  KW_JAVASCRIPT   = "/JavaScript";
  localparam logic [23:0]  KW_JS           = "/JS";
  localparam logic [87:0]  KW_OPENACTION   = "/OpenAction";
  localparam logic [23:0]  KW_AA           = "/AA";
  localparam logic [55:0]  KW_LAUNCH       = "/Launch";
  localparam logic [103:0] KW_EMBEDDEDFILE = "/EmbeddedFile";
  localparam logic [31:0]  HDR_TEXT        = "%PDF";

  localparam logic [7:0] W_JAVASCRIPT   = 8'd20;
  localparam logic [7:0] W_JS           = 8'd20;
  localparam logic [7:0] W_OPENACTION   = 8'd20;
  localparam logic [7:0] W_AA           = 8'd20;
  localparam logic [7:0] W_LAUNCH       = 8'd55;
  localparam logic [7:0] W_EMBEDDEDFILE = 8'd30;

  typedef logic [KW_COUNT-1:0] kw_mask_t;

  // summary of one finished file, passed from front to back
  typedef struct packed {
    logic     scanned;
    kw_mask_t mask;
  } scan_sum_t;

  // expected header byte at position idx (0 = first byte of file)
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    begin
      unique case (idx)
        2'd0:    b = HDR_TEXT[31:24];
        2'd1:    b = HDR_TEXT[23:16];
        2'd2:    b = HDR_TEXT[15:8];
        default: b = HDR_TEXT[7:0];
      endcase
      return b;
    end
  endfunction

  // window: newest byte in [7:0], oldest in [103:96]
  function automatic kw_mask_t kw_hits(input logic [103:0] win);
    kw_mask_t m;
    begin
      m[0] = (win[87:0]  == KW_JAVASCRIPT);
      m[1] = (win[23:0]  == KW_JS);
      m[2] = (win[87:0]  == KW_OPENACTION);
      m[3] = (win[23:0]  == KW_AA);
      m[4] = (win[55:0]  == KW_LAUNCH);
      m[5] = (win[103:0] == KW_EMBEDDEDFILE);
      return m;
    end
  endfunction

  // at most 165, so 8 bits never overflow
  function automatic logic [7:0] score_of(input kw_mask_t m);
    logic [7:0] s;
    begin
      s = 8'd0;
      if (m[0]) s = s + W_JAVASCRIPT;
      if (m[1]) s = s + W_JS;
      if (m[2]) s = s + W_OPENACTION;
      if (m[3]) s = s + W_AA;
      if (m[4]) s = s + W_LAUNCH;
      if (m[5]) s = s + W_EMBEDDEDFILE;
      return s;
    end
  endfunction

endpackage

>>> rtl/core/pks_front.sv
// Front end: byte history, keyword comparators, header check and length count.
// Pushes one scan summary per file into the queue. Depends on pks_pkg.
module pks_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              pdf_by_name,
  input  logic              q_full,
  output logic              q_push,
  output pks_pkg::scan_sum_t q_wdata
);

  logic [95:0]        hist_r, hist_nxt;
  logic [3:0]         seen_r, seen_nxt;
  logic               hdr_r, hdr_nxt;
  pks_pkg::kw_mask_t  found_r, found_nxt;
  logic               accept;
  logic [103:0]       win;

  assign in_stall = q_full;
  assign accept   = in_valid & ~in_stall;
  assign win      = {hist_r, in_data_byte};

  always_comb begin
    found_nxt = found_r | pks_pkg::kw_hits(win);
    hdr_nxt   = hdr_r;
    if (seen_r < pks_pkg::HDR_LEN && in_data_byte != pks_pkg::hdr_byte(seen_r[1:0]))
      hdr_nxt = 1'b0;
    seen_nxt = (seen_r < pks_pkg::MIN_LEN) ? seen_r + 4'd1 : seen_r;
    hist_nxt = {hist_r[87:0], in_data_byte};

    q_push            = accept & in_last_byte;
    q_wdata.scanned   = (seen_nxt >= pks_pkg::MIN_LEN) & (pdf_by_name | hdr_nxt);
    q_wdata.mask      = found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      seen_r  <= '0;
      hdr_r   <= 1'b1;
      found_r <= '0;
    end else if (accept) begin
      if (in_last_byte) begin
        hist_r  <= '0;
        seen_r  <= '0;
        hdr_r   <= 1'b1;
        found_r <= '0;
      end else begin
        hist_r  <= hist_nxt;
        seen_r  <= seen_nxt;
        hdr_r   <= hdr_nxt;
        found_r <= found_nxt;
      end
    end
  end

endmodule

>>> rtl/core/pks_queue.sv
// Two-entry queue of scan summaries between front and back end.
// Depends on pks_pkg.
module pks_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pks_pkg::scan_sum_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output pks_pkg::scan_sum_t rdata
);

  pks_pkg::scan_sum_t mem_r [2];
  logic               wptr_r, rptr_r;
  logic [1:0]         count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rdata     = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/core/pks_back.sv
// Back end: weighs the found keywords, compares with the threshold and
// holds the result in the output register. Depends on pks_pkg.
module pks_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  pks_pkg::scan_sum_t q_rdata,
  output logic               q_pop,
  input  logic [7:0]         threshold,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_flagged,
  output logic [7:0]         out_risk_score,
  output logic [5:0]         out_found_mask
);

  logic       valid_r;
  logic       threat_r, threat_nxt;
  logic [7:0] score_r, score_nxt;
  logic [5:0] mask_r, mask_nxt;

  // output register free, or its transaction completes this cycle
  assign q_pop = q_not_empty & (~valid_r | ~out_stall);

  always_comb begin
    mask_nxt   = q_rdata.scanned ? q_rdata.mask : '0;
    score_nxt  = pks_pkg::score_of(mask_nxt);
    threat_nxt = q_rdata.scanned & (score_nxt >= threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (~out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      threat_r <= threat_nxt;
      score_r  <= score_nxt;
      mask_r   <= mask_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_flagged    = threat_r;
  assign out_risk_score = score_r;
  assign out_found_mask = mask_r;

endmodule

>>> rtl/core/pdf_keyword_threat_scanner_unit.sv
// Scans a file one byte per cycle, while the input is not stalled, for
// /JavaScript, /JS, /OpenAction, /AA, /Launch and /EmbeddedFile and gives one
// verdict per file, on the byte marked last. The result is registered first in
// the queue, then in the output register. The input stalls only when two
// finished verdicts are queued.
module pdf_keyword_threat_scanner_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_flagged,
  output logic [7:0] out_risk_score,
  output logic [5:0] out_found_mask
);

  logic               pdf_by_name_r;
  logic [7:0]         threshold_r;
  logic               q_full, q_push, q_pop, q_not_empty;
  pks_pkg::scan_sum_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pdf_by_name_r <= 1'b0;
      threshold_r   <= pks_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pks_pkg::CFG_PDF_BY_NAME: pdf_by_name_r <= cfg_wdata[0];
        pks_pkg::CFG_THRESHOLD:   threshold_r   <= cfg_wdata;
        default:                  threshold_r   <= threshold_r;
      endcase
    end
  end

  pks_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .pdf_by_name  (pdf_by_name_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  pks_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  pks_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .threshold      (threshold_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_flagged    (out_flagged),
    .out_risk_score (out_risk_score),
    .out_found_mask (out_found_mask)
  );

endmodule
